FILE: hdl/signed_integer_to_radix_digits_unit_defines.svh
// assertion macros shared by the radix text block
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_UNIT_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SIRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sird check failed");

// next-cycle implication, checked out of reset
`define SIRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sird check failed");

`endif

FILE: hdl/sird_pkg.sv
// shared types and constants of the radix text block
`timescale 1ns / 1ps

package sird_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 5;
  localparam int REM_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int MAX_DIGITS = 32;
  localparam int ND_W       = 6;
  localparam int ITER_W     = 5;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/sird_channels.sv
// valid/ready channel interfaces of the radix text block
`timescale 1ns / 1ps

interface sird_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sird_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sird_out_if;
  logic                         valid;
  logic                         ready;
  logic [sird_pkg::CHAR_W-1:0]  text_char;
  logic                         is_last;

  modport source (output valid, output text_char, output is_last, input ready);
  modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

FILE: hdl/sird_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module sird_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sird_pkg::VALUE_W-1:0]  dividend,
  input  logic [sird_pkg::COUNT_W-1:0]  divisor,
  output logic [sird_pkg::VALUE_W-1:0]  quotient,
  output logic [sird_pkg::REM_W-1:0]    remainder,
  output sird_pkg::div_stat_t           stat
);
  import sird_pkg::*;

  logic [VALUE_W-1:0] q_r;
  logic [REM_W-1:0]   rem_r;
  logic [COUNT_W-1:0] divisor_r;
  logic [ITER_W-1:0]  cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [REM_W:0]     trial;
  logic               fits;
  logic [REM_W:0]     diff;

  // shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, q_r[VALUE_W-1]};
    fits  = trial >= divisor_r;
    diff  = trial - divisor_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + ITER_W'(1);
      if (cnt_r == ITER_W'(VALUE_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r       <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[VALUE_W-2:0], fits};
      rem_r <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end
  end

  assign quotient    = q_r;
  assign remainder   = rem_r;
  assign stat.busy   = busy_r;
  assign stat.done   = done_r;

`include "signed_integer_to_radix_digits_unit_defines.svh"

  `SIRD_ASSERT_NOW(a_no_restart_busy, start, !busy_r)
  `SIRD_ASSERT_NOW(a_rem_below_divisor, done_r, {1'b0, rem_r} < divisor_r)
  `SIRD_ASSERT_NEXT(a_done_single, done_r && !start, !done_r)

endmodule

FILE: hdl/signed_integer_to_radix_digits_unit.sv
// top level: signed 32-bit value to text in a programmable radix
`timescale 1ns / 1ps
//
// in_if (sink): one beat carries a signed 32-bit value
// out_if (source): one beat per character, most significant digit first,
//   a leading minus sign for negative values, is_last on the final character
// cfg port: cfg_we writes cfg_wdata into register cfg_index
//   0 alphabet_low, 1 alphabet_high, 2 digit_count (the radix); others ignored
// a value is converted by repeated division of its magnitude by the radix in
//   one shared bit-serial divider (a load, then the quotient bits), digits
//   held in a 32-entry register file
// then the text streams out one character per cycle when the receiver takes it
// in_if.ready is high only while idle; the next value may be taken while the
//   final character still waits in the output register
// an invalid alphabet (radix below 2 or above ALPHABET_SIZE, a plus or minus
//   among used characters, or a repeated used character) drops the value
// a stalled receiver freezes the output register and the character stream
// synchronous reset returns to idle, empty output, config and control regs 0
//
module signed_integer_to_radix_digits_unit #(
  parameter int ALPHABET_SIZE = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sird_in_if.sink                         in_if,
  sird_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sird_pkg::*;

  localparam int DIGIT_W = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  // configuration registers
  logic [CFG_DATA_W-1:0] alpha_lo_r;
  logic [CFG_DATA_W-1:0] alpha_hi_r;
  logic [COUNT_W-1:0]    digit_count_r;

  state_t               state_r;
  logic                 neg_r;          // minus sign still to send
  logic [VALUE_W-1:0]   mag_r;          // dividend of the digit in progress
  logic [ND_W-1:0]      nd_r;           // digits produced so far
  logic [ND_W-1:0]      emit_idx_r;     // digits still to send
  logic [DIGIT_W-1:0]   digits_r [MAX_DIGITS];

  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  logic                 alpha_ok;
  logic                 in_take;
  logic                 div_start;
  logic [VALUE_W-1:0]   div_dividend;
  logic [VALUE_W-1:0]   quotient;
  logic [REM_W-1:0]     remainder;
  div_stat_t            div_stat;
  logic                 load_out;
  logic [ND_W-1:0]      nd_inc;
  logic [DIGIT_W-1:0]   rd_digit;
  logic [3:0]           rd_sel;
  logic [2*CFG_DATA_W-1:0] alpha_all;
  logic [CHAR_W-1:0]    digit_char;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_lo_r    <= '0;
      alpha_hi_r    <= '0;
      digit_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA_LO: alpha_lo_r    <= cfg_wdata;
        CFG_ALPHA_HI: alpha_hi_r    <= cfg_wdata;
        CFG_COUNT:    digit_count_r <= cfg_wdata[COUNT_W-1:0];
        default:      ;
      endcase
    end
  end

  assign alpha_all = {alpha_hi_r, alpha_lo_r};

  // alphabet check: independent compares over the used characters
  always_comb begin
    alpha_ok = (digit_count_r >= COUNT_W'(2)) &&
               (digit_count_r <= COUNT_W'(ALPHABET_SIZE));
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (COUNT_W'(i) < digit_count_r) begin
        if (alpha_all[i*CHAR_W +: CHAR_W] == PLUS_CHAR ||
            alpha_all[i*CHAR_W +: CHAR_W] == MINUS_CHAR) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < ALPHABET_SIZE; j++) begin
          if (COUNT_W'(j) < digit_count_r &&
              alpha_all[j*CHAR_W +: CHAR_W] == alpha_all[i*CHAR_W +: CHAR_W]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign in_take     = in_if.valid && in_if.ready;

  // start on accept, restart straight from a finished digit
  assign nd_inc = nd_r + ND_W'(1);
  always_comb begin
    div_start    = 1'b0;
    div_dividend = mag_r;
    if (state_r == S_IDLE && in_take && alpha_ok) begin
      div_start    = 1'b1;
      div_dividend = in_if.value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_if.value))
                                            : VALUE_W'(in_if.value);
    end else if (state_r == S_DIV && div_stat.done &&
                 quotient != '0 && nd_inc < ND_W'(MAX_DIGITS)) begin
      div_start    = 1'b1;
      div_dividend = quotient;
    end
  end

  sird_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (digit_count_r),
    .quotient  (quotient),
    .remainder (remainder),
    .stat      (div_stat)
  );

  // output register takes a new character when empty or being drained
  assign load_out   = (state_r == S_EMIT) && (!out_valid_r || out_if.ready);
  assign rd_digit   = digits_r[5'(emit_idx_r - ND_W'(1))];
  assign rd_sel     = 4'(rd_digit);
  assign digit_char = alpha_all[rd_sel*CHAR_W +: CHAR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      neg_r       <= 1'b0;
      nd_r        <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take && alpha_ok) begin
            neg_r   <= in_if.value[VALUE_W-1];
            nd_r    <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            nd_r <= nd_inc;
            if (!div_start) begin
              emit_idx_r <= nd_inc;
              state_r    <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (load_out) begin
            if (neg_r) begin
              neg_r <= 1'b0;
            end else begin
              emit_idx_r <= emit_idx_r - ND_W'(1);
              if (emit_idx_r == ND_W'(1)) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload: digit store, dividend, output character
  always_ff @(posedge clk) begin
    if (div_start) begin
      mag_r <= div_dividend;
    end
    if (state_r == S_DIV && div_stat.done) begin
      digits_r[nd_r[4:0]] <= DIGIT_W'(remainder);
    end
    if (load_out) begin
      out_char_r <= neg_r ? MINUS_CHAR : digit_char;
      out_last_r <= !neg_r && (emit_idx_r == ND_W'(1));
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.text_char = out_char_r;
  assign out_if.is_last   = out_last_r;

`include "signed_integer_to_radix_digits_unit_defines.svh"

  `SIRD_ASSERT_NOW(a_done_only_in_div, div_stat.done, state_r == S_DIV)
  `SIRD_ASSERT_NOW(a_busy_only_in_div, div_stat.busy, state_r == S_DIV)
  `SIRD_ASSERT_NOW(a_emit_has_work, state_r == S_EMIT, neg_r || emit_idx_r != '0)
  `SIRD_ASSERT_NOW(a_digit_room, state_r == S_DIV, nd_r < ND_W'(MAX_DIGITS))
  `SIRD_ASSERT_NEXT(a_last_ends_text, load_out && !neg_r && emit_idx_r == ND_W'(1),
                    state_r == S_IDLE && out_if.is_last)

endmodule
